/* rtl/integer_matrix_multiply_unit_macros.svh */
// Assertion macros shared by the checker files of the matrix multiply unit.
`ifndef INTEGER_MATRIX_MULTIPLY_UNIT_MACROS_SVH
`define INTEGER_MATRIX_MULTIPLY_UNIT_MACROS_SVH

// antecedent in this cycle implies consequent in the same cycle
`define IMM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("imm assertion failed");

// antecedent in this cycle implies consequent in the next cycle
`define IMM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("imm assertion failed");

`endif

/* rtl/imm_pkg.sv */
// Shared types and constants of the integer matrix multiply unit.
package imm_pkg;

	localparam int REG_WIDTH     = 4;
	localparam int ADDR_WIDTH    = 4;
	localparam int DATA_WIDTH    = 32;
	localparam int PRODUCT_WIDTH = 36;
	localparam int INDEX_WIDTH   = 3;

	localparam logic [REG_WIDTH-1:0] DIM_RESET = 4'd8;

	localparam logic [1:0] REG_ROWS_A     = 2'd0;
	localparam logic [1:0] REG_INNER_SIZE = 2'd1;
	localparam logic [1:0] REG_COLS_B     = 2'd2;

	typedef struct packed {
		logic [REG_WIDTH-1:0] rows_a;
		logic [REG_WIDTH-1:0] inner_size;
		logic [REG_WIDTH-1:0] cols_b;
	} imm_dims_t;

	typedef struct packed {
		logic issue;
		logic first_k;
		logic last_k;
	} imm_mac_ctl_t;

endpackage

/* rtl/imm_ram.sv */
// Single write port, single registered read port element store.
module imm_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

/* rtl/imm_mac.sv */
// Shared multiply-accumulate unit: registered product, then 36-bit accumulate.
module imm_mac #(
	parameter int ELEM_WIDTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  imm_pkg::imm_mac_ctl_t                 ctl,
	input  logic signed [ELEM_WIDTH-1:0]          a_s1,
	input  logic signed [ELEM_WIDTH-1:0]          b_s1,
	input  logic                                  clr,
	output logic signed [imm_pkg::PRODUCT_WIDTH-1:0] acc_q,
	output logic                                  done_q
);
	import imm_pkg::*;

	localparam int PW = 2 * ELEM_WIDTH;
	localparam int XW = (PW > PRODUCT_WIDTH) ? PW : PRODUCT_WIDTH;

	imm_mac_ctl_t          ctl_s1;
	imm_mac_ctl_t          ctl_s2;
	logic signed [PW-1:0]  prod_s2;
	logic signed [XW-1:0]  prod_x;

	assign prod_x = XW'(prod_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s1 <= ctl;
			ctl_s2 <= ctl_s1;
			if (clr) begin
				done_q <= 1'b0;
			end else if (ctl_s2.issue && ctl_s2.last_k) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= a_s1 * b_s1;
		if (ctl_s2.issue) begin
			acc_q <= (ctl_s2.first_k ? '0 : acc_q) + prod_x[PRODUCT_WIDTH-1:0];
		end
	end

endmodule

/* rtl/imm_cfg.sv */
// APB-style dimension registers of the matrix multiply unit.
module imm_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [imm_pkg::ADDR_WIDTH-1:0]    paddr,
	input  logic [imm_pkg::DATA_WIDTH-1:0]    pwdata,
	output logic [imm_pkg::DATA_WIDTH-1:0]    prdata,
	output logic                              pready,
	output imm_pkg::imm_dims_t                dims_q,
	output logic                              restart
);
	import imm_pkg::*;

	logic       wr;
	logic [1:0] idx;

	assign pready  = 1'b1;
	assign wr      = psel && penable && pwrite;
	assign idx     = paddr[3:2];
	assign restart = wr && (idx == REG_ROWS_A || idx == REG_INNER_SIZE || idx == REG_COLS_B);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q.rows_a     <= DIM_RESET;
			dims_q.inner_size <= DIM_RESET;
			dims_q.cols_b     <= DIM_RESET;
		end else if (wr) begin
			unique case (idx)
				REG_ROWS_A:     dims_q.rows_a     <= pwdata[REG_WIDTH-1:0];
				REG_INNER_SIZE: dims_q.inner_size <= pwdata[REG_WIDTH-1:0];
				REG_COLS_B:     dims_q.cols_b     <= pwdata[REG_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_ROWS_A:     prdata = DATA_WIDTH'(dims_q.rows_a);
			REG_INNER_SIZE: prdata = DATA_WIDTH'(dims_q.inner_size);
			REG_COLS_B:     prdata = DATA_WIDTH'(dims_q.cols_b);
			default:        prdata = '0;
		endcase
	end

endmodule

/* rtl/integer_matrix_multiply_unit.sv */
// Top level of the integer matrix multiply unit: load sequencer and product sequencer.
//
//   channel   direction  handshake                      payload
//   element   in         element_valid / element_stall  element_value
//   product   out        product_valid / product_stall  product_value, row_index, col_index, is_last
//   config    in         psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// Loading takes one element per cycle; element_stall is low throughout the load.
// After the last element of B, each result is computed in turn on the one
// multiply-accumulate unit (one store read per term, registered read and product, accumulate).
// A stalled result holds the sequencer; loading of the next pair resumes once the last
// result sits in the output register. Reset leaves the load empty and all dimensions at 8.
module integer_matrix_multiply_unit #(
	parameter int MAX_DIM    = 8,
	parameter int ELEM_WIDTH = 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     psel,
	input  logic                                     penable,
	input  logic                                     pwrite,
	input  logic [imm_pkg::ADDR_WIDTH-1:0]           paddr,
	input  logic [imm_pkg::DATA_WIDTH-1:0]           pwdata,
	output logic [imm_pkg::DATA_WIDTH-1:0]           prdata,
	output logic                                     pready,
	input  logic                                     element_valid,
	output logic                                     element_stall,
	input  logic signed [ELEM_WIDTH-1:0]             element_value,
	output logic                                     product_valid,
	input  logic                                     product_stall,
	output logic signed [imm_pkg::PRODUCT_WIDTH-1:0] product_value,
	output logic [imm_pkg::INDEX_WIDTH-1:0]          row_index,
	output logic [imm_pkg::INDEX_WIDTH-1:0]          col_index,
	output logic                                     is_last
);
	import imm_pkg::*;

	localparam int IW    = $clog2(MAX_DIM);
	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [2:0] {
		ST_LOAD = 3'b001,
		ST_RUN  = 3'b010,
		ST_WAIT = 3'b100
	} imm_state_t;

	function automatic logic [IW-1:0] dim_limit(input logic [REG_WIDTH-1:0] v);
		if (v == '0) begin
			return '0;
		end
		if (int'(v) > MAX_DIM) begin
			return IW'(MAX_DIM - 1);
		end
		return IW'(v - 1'b1);
	endfunction

	imm_state_t              state_q;
	imm_dims_t               dims_q;
	logic                    restart;
	logic [IW-1:0]           lim_r, lim_k, lim_c;
	logic                    load_b_q;
	logic [IW-1:0]           ld_row_q, ld_col_q;
	logic [IW-1:0]           cr_q, cc_q, ck_q;
	logic                    accept, col_end, row_end;
	logic [AW-1:0]           wr_addr, a_rd_addr, b_rd_addr;
	logic [ELEM_WIDTH-1:0]   a_rd, b_rd;
	imm_mac_ctl_t            ctl;
	logic signed [PRODUCT_WIDTH-1:0] acc;
	logic                    mac_done;
	logic                    take, elem_last;
	logic                    product_valid_q;

	imm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.dims_q  (dims_q),
		.restart (restart)
	);

	assign lim_r = dim_limit(dims_q.rows_a);
	assign lim_k = dim_limit(dims_q.inner_size);
	assign lim_c = dim_limit(dims_q.cols_b);

	assign element_stall = (state_q != ST_LOAD);
	assign accept        = element_valid && !element_stall;
	assign col_end       = (ld_col_q == (load_b_q ? lim_c : lim_k));
	assign row_end       = (ld_row_q == (load_b_q ? lim_k : lim_r));
	assign wr_addr       = AW'(int'(ld_row_q) * MAX_DIM + int'(ld_col_q));
	assign a_rd_addr     = AW'(int'(cr_q) * MAX_DIM + int'(ck_q));
	assign b_rd_addr     = AW'(int'(ck_q) * MAX_DIM + int'(cc_q));

	imm_ram #(.DEPTH(DEPTH), .WIDTH(ELEM_WIDTH)) u_ram_a (
		.clk     (clk),
		.wr_en   (accept && !load_b_q),
		.wr_addr (wr_addr),
		.wr_data (element_value),
		.rd_addr (a_rd_addr),
		.rd_data (a_rd)
	);

	imm_ram #(.DEPTH(DEPTH), .WIDTH(ELEM_WIDTH)) u_ram_b (
		.clk     (clk),
		.wr_en   (accept && load_b_q),
		.wr_addr (wr_addr),
		.wr_data (element_value),
		.rd_addr (b_rd_addr),
		.rd_data (b_rd)
	);

	always_comb begin
		ctl.issue   = (state_q == ST_RUN);
		ctl.first_k = (ck_q == '0);
		ctl.last_k  = (ck_q == lim_k);
	end

	imm_mac #(.ELEM_WIDTH(ELEM_WIDTH)) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.a_s1   (a_rd),
		.b_s1   (b_rd),
		.clr    (take),
		.acc_q  (acc),
		.done_q (mac_done)
	);

	assign take      = (state_q == ST_WAIT) && mac_done && (!product_valid_q || !product_stall);
	assign elem_last = (cr_q == lim_r) && (cc_q == lim_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_LOAD;
			load_b_q        <= 1'b0;
			ld_row_q        <= '0;
			ld_col_q        <= '0;
			cr_q            <= '0;
			cc_q            <= '0;
			ck_q            <= '0;
			product_valid_q <= 1'b0;
		end else begin
			if (take) begin
				product_valid_q <= 1'b1;
			end else if (!product_stall) begin
				product_valid_q <= 1'b0;
			end
			if (restart) begin
				load_b_q <= 1'b0;
				ld_row_q <= '0;
				ld_col_q <= '0;
			end else begin
				unique case (state_q)
					ST_LOAD: begin
						if (accept) begin
							if (col_end) begin
								ld_col_q <= '0;
								if (row_end) begin
									ld_row_q <= '0;
									load_b_q <= !load_b_q;
									if (load_b_q) begin
										cr_q    <= '0;
										cc_q    <= '0;
										ck_q    <= '0;
										state_q <= ST_RUN;
									end
								end else begin
									ld_row_q <= ld_row_q + 1'b1;
								end
							end else begin
								ld_col_q <= ld_col_q + 1'b1;
							end
						end
					end
					ST_RUN: begin
						if (ctl.last_k) begin
							ck_q    <= '0;
							state_q <= ST_WAIT;
						end else begin
							ck_q <= ck_q + 1'b1;
						end
					end
					ST_WAIT: begin
						if (take) begin
							if (elem_last) begin
								cr_q    <= '0;
								cc_q    <= '0;
								state_q <= ST_LOAD;
							end else begin
								if (cc_q == lim_c) begin
									cc_q <= '0;
									cr_q <= cr_q + 1'b1;
								end else begin
									cc_q <= cc_q + 1'b1;
								end
								state_q <= ST_RUN;
							end
						end
					end
					default: state_q <= ST_LOAD;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			product_value <= acc;
			row_index     <= INDEX_WIDTH'(cr_q);
			col_index     <= INDEX_WIDTH'(cc_q);
			is_last       <= elem_last;
		end
	end

	assign product_valid = product_valid_q;

endmodule

/* rtl/imm_checker.sv */
// Port-level checker of the matrix multiply unit and its bind.
`include "integer_matrix_multiply_unit_macros.svh"

module imm_checker (
	input logic                                     clk,
	input logic                                     arst_n,
	input logic                                     element_valid,
	input logic                                     element_stall,
	input logic                                     product_valid,
	input logic                                     product_stall,
	input logic signed [imm_pkg::PRODUCT_WIDTH-1:0] product_value,
	input logic [imm_pkg::INDEX_WIDTH-1:0]          row_index,
	input logic [imm_pkg::INDEX_WIDTH-1:0]          col_index,
	input logic                                     is_last
);

	logic [imm_pkg::PRODUCT_WIDTH+2*imm_pkg::INDEX_WIDTH:0] payload;

	assign payload = {product_value, row_index, col_index, is_last};

	`IMM_ASSERT_NEXT(a_result_held, product_valid && product_stall, product_valid)
	`IMM_ASSERT_NEXT(a_payload_held, product_valid && product_stall, $stable(payload))
	`IMM_ASSERT_NOW(a_stall_after_request, $rose(element_stall), $past(element_valid))
	`IMM_ASSERT_NOW(a_result_from_compute, $rose(product_valid), $past(element_stall))

endmodule

bind integer_matrix_multiply_unit imm_checker u_imm_checker (.*);
